### design/ksrd_pkg.sv
`default_nettype none

package ksrd_pkg;

    localparam int KEY_COUNT   = 16;
    localparam int POS_W       = 4;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int SETTLE_W    = 8;
    localparam int CODE_W      = 7;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd20;
    localparam logic [POS_W-1:0]    LAST_KEY     = 4'd15;
    localparam logic [CODE_W-1:0]   CODE_NONE    = 7'd0;

    // result of one scan tick
    typedef struct packed {
        logic [COL_W-1:0]  column_drive;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } step_result_t;

    // ascii code of each key, row-major
    function automatic logic [CODE_W-1:0] key_ascii(input logic [POS_W-1:0] pos);
        logic [CODE_W-1:0] code;
        unique case (pos)
            4'd0:    code = 7'h20;
            4'd1:    code = 7'h30;
            4'd2:    code = 7'h3D;
            4'd3:    code = 7'h2F;
            4'd4:    code = 7'h37;
            4'd5:    code = 7'h38;
            4'd6:    code = 7'h39;
            4'd7:    code = 7'h2A;
            4'd8:    code = 7'h34;
            4'd9:    code = 7'h35;
            4'd10:   code = 7'h36;
            4'd11:   code = 7'h2D;
            4'd12:   code = 7'h31;
            4'd13:   code = 7'h32;
            4'd14:   code = 7'h33;
            default: code = 7'h2B;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/keypad_scan_release_detect.sv
`default_nettype none

// 4x4 active-low keypad scanner with release detection. Each input beat is one
// scan tick carrying the row pin levels; it yields exactly one output beat with
// the column drive for the key under scan, and on a key release the key's ascii
// code with key_valid set. One beat is taken every clock cycle while out_ready
// keeps up: the scan state is updated in the cycle the beat is accepted, and the
// result is registered in a single output register, refilled in the same cycle it is
// taken. settle_ticks is written on the config channel, which is always ready,
// and resets to 20; it may only be changed while no beat is in flight.
module keypad_scan_release_detect
    import ksrd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [SETTLE_W-1:0] cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ROW_W-1:0]    row_pins,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COL_W-1:0]         column_drive,
    output logic                     key_valid,
    output logic [CODE_W-1:0]        key_code
);

    logic [SETTLE_W-1:0]  settle_ticks_reg;
    logic [POS_W-1:0]     scan_pos_reg;
    logic [POS_W-1:0]     scan_pos_next;
    logic [SETTLE_W-1:0]  settle_cnt_reg;
    logic [SETTLE_W-1:0]  settle_cnt_next;
    logic [KEY_COUNT-1:0] released_reg;
    logic [KEY_COUNT-1:0] released_next;
    step_result_t         step_res;
    step_result_t         result_reg;
    logic                 out_valid_reg;
    logic                 in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_ticks_reg <= SETTLE_RESET;
        else if (cfg_valid && cfg_ready)
            settle_ticks_reg <= cfg_data;
    end

    // per-tick step logic
    ksrd_step u_step (
        .scan_pos        (scan_pos_reg),
        .settle_cnt      (settle_cnt_reg),
        .released        (released_reg),
        .settle_ticks    (settle_ticks_reg),
        .row_pins        (row_pins),
        .scan_pos_next   (scan_pos_next),
        .settle_cnt_next (settle_cnt_next),
        .released_next   (released_next),
        .result          (step_res)
    );

    // scan state, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg   <= '0;
            settle_cnt_reg <= '0;
            released_reg   <= '1;
        end
        else if (in_fire)
        begin
            scan_pos_reg   <= scan_pos_next;
            settle_cnt_reg <= settle_cnt_next;
            released_reg   <= released_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = result_reg.column_drive;
    assign key_valid    = result_reg.key_valid;
    assign key_code     = result_reg.key_code;

    // a release always restarts the scan at key 0
    a_restart_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && step_res.key_valid) |=> (scan_pos_reg == '0))
        else $error("scan did not restart after a release");

    // exactly one column driven low
    a_one_column_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(column_drive) == 3))
        else $error("column drive does not have exactly one low bit");

    // code is zero unless a release is flagged, non-zero when it is
    a_code_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (key_valid ? (key_code != CODE_NONE) : (key_code == CODE_NONE)))
        else $error("key code inconsistent with key_valid");

    // an empty output register never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

### design/ksrd_step.sv
`default_nettype none

module ksrd_step
    import ksrd_pkg::*;
(
    input  wire logic [POS_W-1:0]     scan_pos,
    input  wire logic [SETTLE_W-1:0]  settle_cnt,
    input  wire logic [KEY_COUNT-1:0] released,
    input  wire logic [SETTLE_W-1:0]  settle_ticks,
    input  wire logic [ROW_W-1:0]     row_pins,
    output logic [POS_W-1:0]          scan_pos_next,
    output logic [SETTLE_W-1:0]       settle_cnt_next,
    output logic [KEY_COUNT-1:0]      released_next,
    output step_result_t              result
);

    logic [1:0] row;
    logic [1:0] col;
    logic       level;
    logic       was_released;
    logic       restart;

    assign row          = scan_pos[3:2];
    assign col          = scan_pos[1:0];
    assign level        = row_pins[row];
    assign was_released = released[scan_pos];

    // column drive with the scanned column pulled low, then settle count,
    // sample and update of the released map
    always_comb
    begin
        result.column_drive = '1;
        result.column_drive[2'd3 - col] = 1'b0;
        scan_pos_next    = scan_pos;
        settle_cnt_next  = settle_cnt;
        released_next    = released;
        result.key_valid = 1'b0;
        result.key_code  = CODE_NONE;
        restart          = 1'b0;
        if (settle_cnt < settle_ticks)
        begin
            settle_cnt_next = settle_cnt + 1'b1;
        end
        else
        begin
            settle_cnt_next = '0;
            if (!level && was_released)
            begin
                released_next[scan_pos] = 1'b0;
            end
            else if (level && !was_released)
            begin
                released_next[scan_pos] = 1'b1;
                result.key_valid        = 1'b1;
                result.key_code         = key_ascii(scan_pos);
                restart                 = 1'b1;
            end
            if (restart || scan_pos == LAST_KEY)
                scan_pos_next = '0;
            else
                scan_pos_next = scan_pos + 1'b1;
        end
    end

endmodule

`default_nettype wire
